@@ hw/rtl/interval_group_table_tree_builder_assert.svh @@
// Assertion macros for the group table tree builder; clocked on clk_i, quiet in reset.
`ifndef INTERVAL_GROUP_TABLE_TREE_BUILDER_ASSERT_SVH
`define INTERVAL_GROUP_TABLE_TREE_BUILDER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define IGTB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define IGTB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define IGTB_ASSERT_IMP(label, ante, cons, msg)
`define IGTB_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

@@ hw/rtl/igtb_pkg.sv @@
// Shared constants, codes and state type of the group table tree builder.
`default_nettype none
package igtb_pkg;
  localparam int MAX_LEAVES = 16;
  localparam int MAX_GROUPS = 63;
  localparam int LEAF_LIM   = (MAX_LEAVES < MAX_GROUPS - 1) ? MAX_LEAVES : MAX_GROUPS - 1;
  localparam int AW         = $clog2(MAX_GROUPS);
  localparam int CW         = $clog2(MAX_GROUPS + 1);
  localparam int LEVEL_CAP  = 2048;

  typedef enum logic [1:0] {
    FN_ADD   = 2'd0,
    FN_BUILD = 2'd1,
    FN_READ  = 2'd2,
    FN_NOP   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_LEAF = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_SCAN_RD, S_SCAN_CHK, S_KEEP_WR, S_READ,
    S_BCLR, S_PI_RD, S_PI_LAT, S_PJ_RD, S_PJ_CHK, S_P_WR, S_P_INC,
    S_ML_RD, S_ML_CHK, S_LV_RD, S_LV_WR, S_PS_RD, S_PS_WR,
    S_CL_RD, S_CL_CHK, S_CL_WR
  } state_e;
endpackage
`default_nettype wire

@@ hw/rtl/igtb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module igtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ hw/rtl/interval_group_table_tree_builder.sv @@
// Processor-range group table: add, tree build and node read over shared RAMs.
// Range add scans slots until a match or a free slot, else reports full; build links parents,
// then levels, child offsets and child lists. One item at a time; busy stays high until the
// result strobe. done_o marks a one-cycle result that the receiver must take.
// Reset and each leaf_count write clear the table while busy is high.
`default_nettype none
`include "interval_group_table_tree_builder_assert.svh"
module interval_group_table_tree_builder
  import igtb_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic        [4:0]  cfg_wdata_i,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic        [1:0]  func_i,
  input  wire logic        [3:0]  first_proc_i,
  input  wire logic        [3:0]  last_proc_i,
  input  wire logic        [30:0] path_cost_i,
  input  wire logic        [9:0]  task_depth_i,
  input  wire logic        [5:0]  read_index_i,
  output logic                    done_o,
  output logic             [5:0]  slot_o,
  output logic             [1:0]  status_o,
  output logic signed      [4:0]  node_first_o,
  output logic signed      [4:0]  node_last_o,
  output logic signed      [6:0]  parent_o,
  output logic             [5:0]  child_count_o,
  output logic             [5:0]  first_child_pos_o,
  output logic signed      [12:0] level_value_o,
  output logic signed      [31:0] cost_value_o,
  output logic signed      [6:0]  child_entry_o,
  output logic             [5:0]  group_total_o
);
  state_e state_q, state_d;
  logic [4:0] lc_q, lc_d;
  logic [5:0] grp_q, grp_d;
  logic [CW-1:0] idx_q, idx_d, jdx_q, jdx_d;
  logic [3:0] fp_q, fp_d, lp_q, lp_d;
  logic signed [31:0] ncost_q, ncost_d;
  logic signed [12:0] nlevel_q, nlevel_d;
  logic [5:0] ri_q, ri_d;
  logic signed [4:0] fi_q, fi_d, li_q, li_d;
  logic signed [5:0] span_q, span_d;
  logic signed [6:0] par_q, par_d;
  logic signed [12:0] maxl_q, maxl_d;
  logic [5:0] acc_q, acc_d;
  logic done_q, done_d;
  logic [5:0] slot_q, slot_d;
  logic [1:0] status_q, status_d;
  logic signed [4:0] nf_q, nf_d, nl_q, nl_d;
  logic signed [6:0] rpar_q, rpar_d, ce_q, ce_d;
  logic [5:0] cc_q, cc_d, fc_q, fc_d, gt_q, gt_d;
  logic signed [12:0] lv_q, lv_d;
  logic signed [31:0] cv_q, cv_d;

  // RAM ports
  logic rng_we, inf_we, par_we, ct_we, co_we, cl_we, pl_we;
  logic [AW-1:0] rng_wa, rng_ra, inf_wa, inf_ra, par_wa, par_ra, ct_wa, ct_ra;
  logic [AW-1:0] co_wa, co_ra, cl_wa, cl_ra, pl_wa, pl_ra;
  logic [9:0] rng_wd, rng_rd;
  logic [44:0] inf_wd, inf_rd;
  logic [6:0] par_wd, par_rd, cl_wd, cl_rd;
  logic [5:0] ct_wd, ct_rd, co_wd, co_rd, pl_wd, pl_rd;

  igtb_ram #(.WIDTH(10), .DEPTH(MAX_GROUPS)) u_rng (.clk_i, .we_i(rng_we), .waddr_i(rng_wa),
    .wdata_i(rng_wd), .raddr_i(rng_ra), .rdata_o(rng_rd));
  igtb_ram #(.WIDTH(45), .DEPTH(MAX_GROUPS)) u_inf (.clk_i, .we_i(inf_we), .waddr_i(inf_wa),
    .wdata_i(inf_wd), .raddr_i(inf_ra), .rdata_o(inf_rd));
  igtb_ram #(.WIDTH(7), .DEPTH(MAX_GROUPS)) u_par (.clk_i, .we_i(par_we), .waddr_i(par_wa),
    .wdata_i(par_wd), .raddr_i(par_ra), .rdata_o(par_rd));
  igtb_ram #(.WIDTH(6), .DEPTH(MAX_GROUPS)) u_ct (.clk_i, .we_i(ct_we), .waddr_i(ct_wa),
    .wdata_i(ct_wd), .raddr_i(ct_ra), .rdata_o(ct_rd));
  igtb_ram #(.WIDTH(6), .DEPTH(MAX_GROUPS)) u_co (.clk_i, .we_i(co_we), .waddr_i(co_wa),
    .wdata_i(co_wd), .raddr_i(co_ra), .rdata_o(co_rd));
  igtb_ram #(.WIDTH(7), .DEPTH(MAX_GROUPS)) u_cl (.clk_i, .we_i(cl_we), .waddr_i(cl_wa),
    .wdata_i(cl_wd), .raddr_i(cl_ra), .rdata_o(cl_rd));
  igtb_ram #(.WIDTH(6), .DEPTH(MAX_GROUPS)) u_pl (.clk_i, .we_i(pl_we), .waddr_i(pl_wa),
    .wdata_i(pl_wd), .raddr_i(pl_ra), .rdata_o(pl_rd));

  // decoded read data and shared compare logic
  logic signed [4:0] rf_w, rl_w;
  logic signed [31:0] cost_w, kcost_w;
  logic signed [12:0] lvl_w, klvl_w;
  logic signed [5:0] sj_w;
  logic signed [14:0] lsum_w;
  logic signed [6:0] prd_w;
  logic [CW-1:0] n_w, lcx_w, idx_inc;
  logic [AW-1:0] idx_a;
  logic match_w, free_w, encl_w, leaf_ok, fin_last, work_w;
  logic [6:0] pos_w;
  func_e fn_w;

  assign rf_w    = $signed(rng_rd[9:5]);
  assign rl_w    = $signed(rng_rd[4:0]);
  assign cost_w  = $signed(inf_rd[44:13]);
  assign lvl_w   = $signed(inf_rd[12:0]);
  assign prd_w   = $signed(par_rd);
  assign kcost_w = (ncost_q < cost_w) ? ncost_q : cost_w;
  assign klvl_w  = (nlevel_q < lvl_w) ? nlevel_q : lvl_w;
  assign sj_w    = $signed({rl_w[4], rl_w}) - $signed({rf_w[4], rf_w});
  assign lsum_w  = $signed({{2{maxl_q[12]}}, maxl_q}) + 15'sd1
                 - $signed({{2{lvl_w[12]}}, lvl_w});
  assign n_w     = CW'(grp_q);
  assign lcx_w   = CW'(lc_q);
  assign idx_inc = idx_q + CW'(1);
  assign idx_a   = idx_q[AW-1:0];
  assign match_w = (rf_w == $signed({1'b0, fp_q})) && (rl_w == $signed({1'b0, lp_q}));
  assign free_w  = (rf_w == -5'sd1);
  assign encl_w  = (jdx_q != idx_q) && (fi_q >= rf_w) && (li_q <= rl_w) && (span_q > sj_w);
  assign leaf_ok = {1'b0, first_proc_i} < lc_q;
  assign fin_last = (idx_inc == n_w);
  assign pos_w   = {1'b0, co_rd} + {1'b0, pl_rd};
  assign fn_w    = func_e'(func_i);
  assign busy    = (state_q != S_IDLE);
  // transfer that leaves idle: not a no-op and not a rejected leaf add
  assign work_w  = start && !busy && (fn_w != FN_NOP)
                 && !(fn_w == FN_ADD && first_proc_i == last_proc_i && !leaf_ok);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (fn_w)
            FN_ADD: begin
              if (first_proc_i == last_proc_i) begin
                state_d = leaf_ok ? S_KEEP_WR : S_IDLE;
              end else begin
                state_d = S_SCAN_RD;
              end
            end
            FN_BUILD: state_d = S_BCLR;
            FN_READ:  state_d = S_READ;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_INIT:     if (idx_q == CW'(MAX_GROUPS - 1)) state_d = S_IDLE;
      S_SCAN_RD:  state_d = (idx_q == CW'(MAX_GROUPS)) ? S_IDLE : S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (match_w) begin
          state_d = S_KEEP_WR;
        end else if (free_w) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_KEEP_WR:  state_d = S_IDLE;
      S_READ:     state_d = S_IDLE;
      S_BCLR:     if (idx_q == CW'(MAX_GROUPS - 1)) state_d = S_PI_RD;
      S_PI_RD:    state_d = S_PI_LAT;
      S_PI_LAT:   state_d = S_PJ_RD;
      S_PJ_RD:    state_d = (jdx_q == n_w) ? S_P_WR : S_PJ_CHK;
      S_PJ_CHK:   state_d = S_PJ_RD;
      S_P_WR: begin
        if (par_q >= 0) begin
          state_d = S_P_INC;
        end else begin
          state_d = fin_last ? S_ML_RD : S_PI_RD;
        end
      end
      S_P_INC:    state_d = fin_last ? S_ML_RD : S_PI_RD;
      S_ML_RD:    state_d = (idx_q == n_w) ? S_LV_RD : S_ML_CHK;
      S_ML_CHK:   state_d = S_ML_RD;
      S_LV_RD:    state_d = (idx_q == n_w) ? S_PS_RD : S_LV_WR;
      S_LV_WR:    state_d = S_LV_RD;
      S_PS_RD:    state_d = (idx_q == n_w) ? S_CL_RD : S_PS_WR;
      S_PS_WR:    state_d = S_PS_RD;
      S_CL_RD:    state_d = (idx_q == n_w) ? S_IDLE : S_CL_CHK;
      S_CL_CHK:   state_d = (prd_w >= 0) ? S_CL_WR : S_CL_RD;
      S_CL_WR:    state_d = S_CL_RD;
      default:    state_d = S_IDLE;
    endcase
    if (cfg_we_i) begin
      state_d = S_INIT;
    end
  end

  // datapath, RAM control and results
  always_comb begin
    lc_d = lc_q; grp_d = grp_q; idx_d = idx_q; jdx_d = jdx_q;
    fp_d = fp_q; lp_d = lp_q; ncost_d = ncost_q; nlevel_d = nlevel_q; ri_d = ri_q;
    fi_d = fi_q; li_d = li_q; span_d = span_q; par_d = par_q; maxl_d = maxl_q;
    acc_d = acc_q; done_d = 1'b0;
    slot_d = slot_q; status_d = status_q; nf_d = nf_q; nl_d = nl_q; rpar_d = rpar_q;
    cc_d = cc_q; fc_d = fc_q; lv_d = lv_q; cv_d = cv_q; ce_d = ce_q; gt_d = gt_q;
    rng_we = 1'b0; inf_we = 1'b0; par_we = 1'b0; ct_we = 1'b0;
    co_we = 1'b0; cl_we = 1'b0; pl_we = 1'b0;
    rng_wa = idx_a; inf_wa = idx_a; par_wa = idx_a; ct_wa = idx_a;
    co_wa = idx_a; cl_wa = idx_a; pl_wa = idx_a;
    rng_ra = idx_a; inf_ra = idx_a; par_ra = idx_a; ct_ra = idx_a;
    co_ra = idx_a; cl_ra = idx_a; pl_ra = idx_a;
    rng_wd = '1; inf_wd = '0; par_wd = '1; ct_wd = '0; co_wd = '0; cl_wd = '1; pl_wd = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          fp_d     = first_proc_i;
          lp_d     = last_proc_i;
          ncost_d  = 32'sd0 - $signed({1'b0, path_cost_i});
          nlevel_d = 13'sd0 - $signed({3'b0, task_depth_i});
          ri_d     = read_index_i;
          idx_d    = lcx_w;
          slot_d   = '0;
          status_d = ST_OK;
          nf_d = '0; nl_d = '0; rpar_d = '0; cc_d = '0; fc_d = '0;
          lv_d = '0; cv_d = '0; ce_d = '0;
          inf_ra   = AW'(first_proc_i);
          rng_ra   = read_index_i[AW-1:0];
          par_ra   = read_index_i[AW-1:0];
          ct_ra    = read_index_i[AW-1:0];
          co_ra    = read_index_i[AW-1:0];
          cl_ra    = read_index_i[AW-1:0];
          case (fn_w)
            FN_ADD: begin
              if (first_proc_i == last_proc_i) begin
                slot_d = {2'b0, first_proc_i};
                if (!leaf_ok) begin
                  slot_d   = '0;
                  status_d = ST_LEAF;
                  gt_d     = grp_q;
                  done_d   = 1'b1;
                end
              end
            end
            FN_BUILD: idx_d = '0;
            FN_READ:  inf_ra = read_index_i[AW-1:0];
            default:  idx_d = idx_q;
          endcase
        end
      end
      S_INIT: begin
        rng_we = 1'b1; inf_we = 1'b1; par_we = 1'b1; ct_we = 1'b1;
        co_we = 1'b1; cl_we = 1'b1; pl_we = 1'b1;
        if (idx_q < lcx_w) begin
          rng_wd = {idx_q[4:0], idx_q[4:0]};
        end
        grp_d = {1'b0, lc_q};
        idx_d = idx_inc;
      end
      S_SCAN_RD: begin
        if (idx_q == CW'(MAX_GROUPS)) begin
          status_d = ST_FULL;
          gt_d     = grp_q;
          done_d   = 1'b1;
        end
      end
      S_SCAN_CHK: begin
        if (match_w) begin
          slot_d = 6'(idx_q);
        end else if (free_w) begin
          rng_we = 1'b1;
          rng_wd = {1'b0, fp_q, 1'b0, lp_q};
          inf_we = 1'b1;
          inf_wd = {ncost_q, nlevel_q};
          grp_d  = grp_q + 6'd1;
          slot_d = 6'(idx_q);
          gt_d   = grp_q + 6'd1;
          done_d = 1'b1;
        end else begin
          idx_d = idx_inc;
        end
      end
      S_KEEP_WR: begin
        inf_we = 1'b1;
        inf_wa = slot_q[AW-1:0];
        inf_wd = {kcost_w, klvl_w};
        gt_d   = grp_q;
        done_d = 1'b1;
      end
      S_READ: begin
        gt_d   = grp_q;
        done_d = 1'b1;
        if (ri_q < 6'(MAX_GROUPS)) begin
          nf_d = rf_w; nl_d = rl_w; rpar_d = prd_w;
          cc_d = ct_rd; fc_d = co_rd; lv_d = lvl_w; cv_d = cost_w;
          ce_d = $signed(cl_rd);
        end else begin
          nf_d = -5'sd1; nl_d = -5'sd1; rpar_d = -7'sd1; ce_d = -7'sd1;
        end
      end
      S_BCLR: begin
        par_we = 1'b1; ct_we = 1'b1; co_we = 1'b1; cl_we = 1'b1; pl_we = 1'b1;
        idx_d = (idx_q == CW'(MAX_GROUPS - 1)) ? '0 : idx_inc;
      end
      S_PI_RD: ;
      S_PI_LAT: begin
        fi_d   = rf_w;
        li_d   = rl_w;
        span_d = $signed({1'b0, lc_q});
        par_d  = -7'sd1;
        jdx_d  = lcx_w;
      end
      S_PJ_RD: rng_ra = jdx_q[AW-1:0];
      S_PJ_CHK: begin
        if (encl_w) begin
          span_d = sj_w;
          par_d  = $signed(7'(jdx_q));
        end
        jdx_d = jdx_q + CW'(1);
      end
      S_P_WR: begin
        par_we = 1'b1;
        par_wd = par_q;
        ct_ra  = par_q[AW-1:0];
        if (par_q < 0) begin
          idx_d  = fin_last ? lcx_w : idx_inc;
          maxl_d = '0;
        end
      end
      S_P_INC: begin
        ct_we  = 1'b1;
        ct_wa  = par_q[AW-1:0];
        ct_wd  = ct_rd + 6'd1;
        idx_d  = fin_last ? lcx_w : idx_inc;
        maxl_d = '0;
      end
      S_ML_RD: if (idx_q == n_w) idx_d = lcx_w;
      S_ML_CHK: begin
        if (lvl_w > maxl_q) maxl_d = lvl_w;
        idx_d = idx_inc;
      end
      S_LV_RD: begin
        if (idx_q == n_w) begin
          idx_d = '0;
          acc_d = '0;
        end
      end
      S_LV_WR: begin
        inf_we = 1'b1;
        inf_wd = {cost_w, (lsum_w > 15'(LEVEL_CAP)) ? 13'(LEVEL_CAP) : lsum_w[12:0]};
        idx_d  = idx_inc;
      end
      S_PS_RD: if (idx_q == n_w) idx_d = '0;
      S_PS_WR: begin
        co_we = 1'b1;
        co_wd = acc_q;
        acc_d = acc_q + ct_rd;
        idx_d = idx_inc;
      end
      S_CL_RD: begin
        if (idx_q == n_w) begin
          gt_d   = grp_q;
          done_d = 1'b1;
        end
      end
      S_CL_CHK: begin
        co_ra = prd_w[AW-1:0];
        pl_ra = prd_w[AW-1:0];
        par_d = prd_w;
        if (prd_w < 0) idx_d = idx_inc;
      end
      S_CL_WR: begin
        if (pos_w < 7'(MAX_GROUPS)) begin
          cl_we = 1'b1;
          cl_wa = pos_w[AW-1:0];
          cl_wd = 7'(idx_q);
        end
        pl_we = 1'b1;
        pl_wa = par_q[AW-1:0];
        pl_wd = pl_rd + 6'd1;
        idx_d = idx_inc;
      end
      default: ;
    endcase

    if (cfg_we_i) begin
      // saturate to the supported leaf range, then sweep the table
      if (cfg_wdata_i == 5'd0) begin
        lc_d = 5'd1;
      end else if (cfg_wdata_i > 5'(LEAF_LIM)) begin
        lc_d = 5'(LEAF_LIM);
      end else begin
        lc_d = cfg_wdata_i;
      end
      idx_d  = '0;
      done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      lc_q    <= 5'(LEAF_LIM);
      grp_q   <= 6'(LEAF_LIM);
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      lc_q    <= lc_d;
      grp_q   <= grp_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    jdx_q <= jdx_d; fp_q <= fp_d; lp_q <= lp_d; ncost_q <= ncost_d; nlevel_q <= nlevel_d;
    ri_q <= ri_d; fi_q <= fi_d; li_q <= li_d; span_q <= span_d; par_q <= par_d;
    maxl_q <= maxl_d; acc_q <= acc_d;
    slot_q <= slot_d; status_q <= status_d; nf_q <= nf_d; nl_q <= nl_d; rpar_q <= rpar_d;
    cc_q <= cc_d; fc_q <= fc_d; lv_q <= lv_d; cv_q <= cv_d; ce_q <= ce_d; gt_q <= gt_d;
  end

  assign done_o            = done_q;
  assign slot_o            = slot_q;
  assign status_o          = status_q;
  assign node_first_o      = nf_q;
  assign node_last_o       = nl_q;
  assign parent_o          = rpar_q;
  assign child_count_o     = cc_q;
  assign first_child_pos_o = fc_q;
  assign level_value_o     = lv_q;
  assign cost_value_o      = cv_q;
  assign child_entry_o     = ce_q;
  assign group_total_o     = gt_q;

  `IGTB_ASSERT_IMP(a_done_idle, done_q, state_q == S_IDLE, "result strobe outside idle")
  `IGTB_ASSERT_NXT(a_start_busy, work_w && !cfg_we_i, busy, "accepted item did not start work")
  `IGTB_ASSERT_IMP(a_grp_floor, state_q != S_INIT, grp_q >= {1'b0, lc_q}, "group count below leaf count")
  `IGTB_ASSERT_IMP(a_grp_cap, 1'b1, grp_q <= 6'(MAX_GROUPS), "group count above table size")
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the processor-range group table and tree builder.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import igtb_pkg::*;

  typedef struct packed {
    logic [5:0]  slot;
    logic [1:0]  status;
    logic [4:0]  node_first;
    logic [4:0]  node_last;
    logic [6:0]  parent;
    logic [5:0]  child_count;
    logic [5:0]  first_child_pos;
    logic [12:0] level_value;
    logic [31:0] cost_value;
    logic [6:0]  child_entry;
    logic [5:0]  group_total;
  } node_result_t;

  typedef struct packed {
    func_e       func;
    logic [3:0]  first_proc;
    logic [3:0]  last_proc;
    logic [30:0] path_cost;
    logic [9:0]  task_depth;
    logic [5:0]  read_index;
  } group_cmd_t;

  class group_tree_scoreboard;
    int leaves;
    int rng_first[MAX_GROUPS];
    int rng_last[MAX_GROUPS];
    int min_cost[MAX_GROUPS];
    int level[MAX_GROUPS];
    int parent_of[MAX_GROUPS];
    int kids[MAX_GROUPS];
    int kid_base[MAX_GROUPS];
    int kid_list[MAX_GROUPS];
    int used;
    int errors;
    node_result_t pending_results[$];

    function new();
      errors = 0;
      set_leaves(16);
    endfunction

    function void set_leaves(int value);
      leaves = (value < 1) ? 1 : (value > LEAF_LIM) ? LEAF_LIM : value;
      for (int i = 0; i < MAX_GROUPS; i++) begin
        rng_first[i] = (i < leaves) ? i : -1;
        rng_last[i]  = (i < leaves) ? i : -1;
        min_cost[i]  = 0;
        level[i]     = 0;
        parent_of[i] = -1;
        kids[i]      = 0;
        kid_base[i]  = 0;
        kid_list[i]  = -1;
      end
      used = leaves;
    endfunction

    function void keep_min(int i, int ncost, int nlevel);
      if (ncost < min_cost[i]) min_cost[i] = ncost;
      if (nlevel < level[i]) level[i] = nlevel;
    endfunction

    function void build_tree();
      int n;
      int span;
      int sj;
      int top;
      int v;
      int p;
      int pos;
      int placed[MAX_GROUPS];
      n = used;
      top = 0;
      for (int i = 0; i < MAX_GROUPS; i++) begin
        parent_of[i] = -1;
        kids[i] = 0;
        kid_list[i] = -1;
        placed[i] = 0;
      end
      for (int i = 0; i < n; i++) begin
        span = leaves;
        for (int j = leaves; j < n; j++) begin
          sj = rng_last[j] - rng_first[j];
          if (i != j && rng_first[i] >= rng_first[j] && rng_last[i] <= rng_last[j]
              && span > sj) begin
            span = sj;
            parent_of[i] = j;
          end
        end
        if (parent_of[i] >= 0) kids[parent_of[i]]++;
      end
      for (int i = leaves; i < n; i++)
        if (level[i] > top) top = level[i];
      for (int i = leaves; i < n; i++) begin
        v = top + 1 - level[i];
        level[i] = (v > LEVEL_CAP) ? LEVEL_CAP : v;
      end
      if (n > 0) kid_base[0] = 0;
      for (int i = 1; i < n; i++) kid_base[i] = kid_base[i-1] + kids[i-1];
      for (int i = 0; i < n; i++) begin
        p = parent_of[i];
        if (p >= 0 && p < MAX_GROUPS) begin
          pos = kid_base[p] + placed[p];
          if (pos >= 0 && pos < MAX_GROUPS) kid_list[pos] = i;
          placed[p]++;
        end
      end
    endfunction

    // Applies one accepted command and queues the result it should produce, if any.
    function void note_command(group_cmd_t c);
      node_result_t r;
      int fp;
      int lp;
      int ncost;
      int nlevel;
      int ri;
      fp = int'(c.first_proc);
      lp = int'(c.last_proc);
      ncost = -int'({1'b0, c.path_cost});
      nlevel = -int'(c.task_depth);
      ri = int'(c.read_index);
      r = '0;
      if (c.func == FN_NOP) return;
      if (c.func == FN_ADD) begin
        if (fp == lp) begin
          if (fp < leaves) begin
            keep_min(fp, ncost, nlevel);
            r.slot = 6'(fp);
          end else r.status = ST_LEAF;
        end else begin
          r.status = ST_FULL;
          for (int i = leaves; i < MAX_GROUPS; i++) begin
            if (rng_first[i] == fp && rng_last[i] == lp) begin
              keep_min(i, ncost, nlevel);
              r.slot = 6'(i);
              r.status = ST_OK;
              break;
            end
            if (rng_first[i] == -1) begin
              rng_first[i] = fp;
              rng_last[i] = lp;
              min_cost[i] = ncost;
              level[i] = nlevel;
              used++;
              r.slot = 6'(i);
              r.status = ST_OK;
              break;
            end
          end
        end
      end else if (c.func == FN_BUILD) begin
        build_tree();
      end else if (ri < MAX_GROUPS) begin
        r.node_first = 5'(rng_first[ri]);
        r.node_last = 5'(rng_last[ri]);
        r.parent = 7'(parent_of[ri]);
        r.child_count = 6'(kids[ri]);
        r.first_child_pos = 6'(kid_base[ri]);
        r.level_value = 13'(level[ri]);
        r.cost_value = 32'(min_cost[ri]);
        r.child_entry = 7'(kid_list[ri]);
      end else begin
        r.node_first = '1;
        r.node_last = '1;
        r.parent = '1;
        r.child_entry = '1;
      end
      r.group_total = 6'(used);
      pending_results.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: %s got %0h expected %0h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(node_result_t got);
      node_result_t want;
      if (pending_results.size() == 0) begin
        report("unexpected result, slot", 32'(got.slot), 0);
        return;
      end
      want = pending_results.pop_front();
      if (got.slot !== want.slot) report("slot", 32'(got.slot), 32'(want.slot));
      if (got.status !== want.status) report("status", 32'(got.status), 32'(want.status));
      if (got.node_first !== want.node_first)
        report("node_first", 32'(got.node_first), 32'(want.node_first));
      if (got.node_last !== want.node_last)
        report("node_last", 32'(got.node_last), 32'(want.node_last));
      if (got.parent !== want.parent) report("parent", 32'(got.parent), 32'(want.parent));
      if (got.child_count !== want.child_count)
        report("child_count", 32'(got.child_count), 32'(want.child_count));
      if (got.first_child_pos !== want.first_child_pos)
        report("first_child_pos", 32'(got.first_child_pos), 32'(want.first_child_pos));
      if (got.level_value !== want.level_value)
        report("level_value", 32'(got.level_value), 32'(want.level_value));
      if (got.cost_value !== want.cost_value)
        report("cost_value", got.cost_value, want.cost_value);
      if (got.child_entry !== want.child_entry)
        report("child_entry", 32'(got.child_entry), 32'(want.child_entry));
      if (got.group_total !== want.group_total)
        report("group_total", 32'(got.group_total), 32'(want.group_total));
    endtask
  endclass

  localparam int IDLE_LIMIT = 40000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [4:0] cfg_wdata_i;
  logic start;
  logic busy;
  logic [1:0] func_i;
  logic [3:0] first_proc_i;
  logic [3:0] last_proc_i;
  logic [30:0] path_cost_i;
  logic [9:0] task_depth_i;
  logic [5:0] read_index_i;
  logic done_o;
  logic [5:0] slot_o;
  logic [1:0] status_o;
  logic signed [4:0] node_first_o;
  logic signed [4:0] node_last_o;
  logic signed [6:0] parent_o;
  logic [5:0] child_count_o;
  logic [5:0] first_child_pos_o;
  logic signed [12:0] level_value_o;
  logic signed [31:0] cost_value_o;
  logic signed [6:0] child_entry_o;
  logic [5:0] group_total_o;

  group_tree_scoreboard sb = new();
  int idle_cycles = 0;

  interval_group_table_tree_builder dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .start, .busy,
    .func_i, .first_proc_i, .last_proc_i, .path_cost_i, .task_depth_i, .read_index_i,
    .done_o, .slot_o, .status_o, .node_first_o, .node_last_o, .parent_o,
    .child_count_o, .first_child_pos_o, .level_value_o, .cost_value_o,
    .child_entry_o, .group_total_o
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      sb.check_result({slot_o, status_o, node_first_o, node_last_o, parent_o,
                       child_count_o, first_child_pos_o, level_value_o,
                       cost_value_o, child_entry_o, group_total_o});
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Holds the command until a transfer, then notes it.
  task issue(group_cmd_t c);
    func_i <= c.func;
    first_proc_i <= c.first_proc;
    last_proc_i <= c.last_proc;
    path_cost_i <= c.path_cost;
    task_depth_i <= c.task_depth;
    read_index_i <= c.read_index;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    sb.note_command(c);
  endtask

  task issue_gapped(group_cmd_t c);
    int gap;
    issue(c);
    gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task write_leaves(logic [4:0] value);
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() > 0) @(posedge clk_i);
    // a no-op command may still be in flight
    repeat (120) @(posedge clk_i);
    while (busy) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_leaves(int'(value));
    repeat (2) @(posedge clk_i);
  endtask

  function automatic group_cmd_t make_cmd(func_e f, int fp, int lp, logic [30:0] pc,
                                          logic [9:0] d, int ri);
    group_cmd_t c;
    c.func = f;
    c.first_proc = 4'(fp);
    c.last_proc = 4'(lp);
    c.path_cost = pc;
    c.task_depth = d;
    c.read_index = 6'(ri);
    return c;
  endfunction

  function automatic group_cmd_t random_cmd();
    group_cmd_t c;
    int pick;
    int a;
    int b;
    int lim;
    pick = $urandom_range(0, 99);
    lim = sb.leaves - 1;
    c.path_cost = ($urandom_range(0, 3) == 0) ? 31'h7FFF_FFFF : 31'($urandom);
    c.task_depth = ($urandom_range(0, 3) == 0) ? 10'd1023 : 10'($urandom);
    c.first_proc = 4'($urandom);
    c.last_proc = 4'($urandom);
    c.read_index = 6'($urandom_range(0, sb.used));
    if (pick < 55) begin
      c.func = FN_ADD;
      if (pick < 10) c.last_proc = c.first_proc;
      else if (pick < 45) begin
        a = $urandom_range(0, lim);
        b = $urandom_range(0, lim);
        c.first_proc = 4'((a < b) ? a : b);
        c.last_proc = 4'((a < b) ? b : a);
      end
    end else if (pick < 63) c.func = FN_BUILD;
    else if (pick < 96) begin
      c.func = FN_READ;
      if (pick > 93) c.read_index = 6'($urandom_range(0, 63));
    end else c.func = FN_NOP;
    return c;
  endfunction

  int phase_leaves[8] = '{16, 1, 0, 31, 5, 16, 9, 2};

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    start = 1'b0;
    func_i = FN_NOP;
    first_proc_i = '0;
    last_proc_i = '0;
    path_cost_i = '0;
    task_depth_i = '0;
    read_index_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, duplicates, odd ranges, rebuilds, out-of-range reads
    issue_gapped(make_cmd(FN_ADD, 0, 0, 31'h7FFF_FFFF, 10'd1023, 0));
    issue_gapped(make_cmd(FN_ADD, 15, 15, 31'd0, 10'd0, 0));
    issue_gapped(make_cmd(FN_ADD, 3, 7, 31'h0001_8000, 10'd5, 0));
    issue_gapped(make_cmd(FN_ADD, 7, 3, 31'd1, 10'd1, 0));
    issue_gapped(make_cmd(FN_ADD, 3, 7, 31'h7FFF_FFFF, 10'd1023, 0));
    issue_gapped(make_cmd(FN_ADD, 0, 15, 31'h5555_5555, 10'h2AA, 0));
    issue_gapped(make_cmd(FN_NOP, 0, 0, 31'd0, 10'd0, 0));
    issue_gapped(make_cmd(FN_BUILD, 0, 0, 31'd0, 10'd0, 0));
    issue_gapped(make_cmd(FN_BUILD, 0, 0, 31'd0, 10'd0, 0));
    issue_gapped(make_cmd(FN_ADD, 4, 6, 31'h2AAA_AAAA, 10'd1023, 0));
    issue_gapped(make_cmd(FN_BUILD, 0, 0, 31'd0, 10'd0, 0));
    for (int i = 0; i < 20; i++) issue_gapped(make_cmd(FN_READ, 0, 0, 31'd0, 10'd0, i));
    issue_gapped(make_cmd(FN_READ, 0, 0, 31'd0, 10'd0, 63));
    write_leaves(5'd5);
    issue_gapped(make_cmd(FN_ADD, 9, 9, 31'd7, 10'd7, 0));
    issue_gapped(make_cmd(FN_ADD, 4, 4, 31'd7, 10'd7, 0));

    // random phases over several leaf counts, table filling up along the way
    foreach (phase_leaves[p]) begin
      write_leaves(5'(phase_leaves[p]));
      for (int k = 0; k < 85; k++) issue_gapped(random_cmd());
      issue_gapped(make_cmd(FN_BUILD, 0, 0, 31'd0, 10'd0, 0));
      for (int i = 0; i < 64; i += 7)
        issue_gapped(make_cmd(FN_READ, 0, 0, 31'd0, 10'd0, i));
    end

    start <= 1'b0;
    while (sb.pending_results.size() > 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ files.f @@
+incdir+hw/rtl
hw/rtl/igtb_pkg.sv
hw/rtl/igtb_ram.sv
hw/rtl/interval_group_table_tree_builder.sv
tb/tb_top.sv
